// File: src/scq_pkg.sv
// Shared op codes, status codes and chain command type for the sorted contraction queue.
package scq_pkg;

   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_FIND   = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;

   // command broadcast to every cell of the chain
   typedef struct packed {
      logic [1:0] op;
      logic       commit_push;
      logic       commit_del;
   } scq_cmd_type;

endpackage

// File: src/scq_cell.sv
// One cell of the sorted list: holds one entry and one stage of the search probe.
module scq_cell #(
   parameter int QUEUE_DEPTH = 256,
   parameter int VERTEX_BITS = 16,
   parameter int INDEX       = 0
) (
   input  logic                                 clock,
   input  scq_pkg::scq_cmd_type                 cmd,
   input  logic [4*32+2*VERTEX_BITS-1:0]        key_entry,
   input  logic [7:0]                           slot,
   input  logic [$clog2(QUEUE_DEPTH)-1:0]       at_idx,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]     total,
   input  logic [4*32+2*VERTEX_BITS-1:0]        prev_entry,
   input  logic [4*32+2*VERTEX_BITS-1:0]        next_entry,
   input  logic [1+$clog2(QUEUE_DEPTH)+4*32+2*VERTEX_BITS-1:0] probe_prev,
   output logic [4*32+2*VERTEX_BITS-1:0]        entry_out,
   output logic [1+$clog2(QUEUE_DEPTH)+4*32+2*VERTEX_BITS-1:0] probe_out
);
   import scq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [31:0]            cost;
      logic [VERTEX_BITS-1:0] va;
      logic [VERTEX_BITS-1:0] vb;
      logic [31:0]            pos_x;
      logic [31:0]            pos_y;
      logic [31:0]            pos_z;
   } entry_type;

   typedef struct packed {
      logic          hit;
      logic [IW-1:0] idx;
      entry_type     entry;
   } probe_type;

   localparam logic [IW-1:0] MY_IDX     = IW'(INDEX);
   localparam logic [CW-1:0] MY_CNT     = CW'(INDEX);
   localparam logic [7:0]    MY_SLOT    = 8'(INDEX);
   localparam bit            SLOT_REACH = (INDEX < 256);

   entry_type entry_ff, entry_in;
   entry_type key, prev_e, next_e;
   probe_type probe_ff, probe_in, probe_up;
   logic      occupied, edge_match, slot_match, here_hit;

   assign key      = entry_type'(key_entry);
   assign prev_e   = entry_type'(prev_entry);
   assign next_e   = entry_type'(next_entry);
   assign probe_up = probe_type'(probe_prev);

   assign occupied   = MY_CNT < total;
   assign edge_match = (entry_ff.va == key.va && entry_ff.vb == key.vb) ||
                       (entry_ff.va == key.vb && entry_ff.vb == key.va);
   assign slot_match = SLOT_REACH && (slot == MY_SLOT);

   // per-op hit test on this cell
   always_comb begin
      case (cmd.op)
         OP_PUSH: here_hit = !(occupied && entry_ff.cost >= key.cost);
         OP_FIND: here_hit = occupied && edge_match;
         default: here_hit = occupied && slot_match;
      endcase
   end

   // first hit along the chain wins
   always_comb begin
      probe_in = probe_up;
      if (!probe_up.hit && here_hit) begin
         probe_in.hit   = 1'b1;
         probe_in.idx   = MY_IDX;
         probe_in.entry = entry_ff;
      end
   end

   // insert opens a gap at at_idx, delete closes one there
   always_comb begin
      entry_in = entry_ff;
      if (cmd.commit_push) begin
         if (MY_IDX > at_idx) begin
            entry_in = prev_e;
         end else if (MY_IDX == at_idx) begin
            entry_in = key;
         end
      end else if (cmd.commit_del) begin
         if (MY_IDX >= at_idx) begin
            entry_in = next_e;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      probe_ff <= probe_in;
   end

   assign entry_out = entry_ff;
   assign probe_out = probe_ff;

endmodule

// File: src/sorted_contraction_queue_unit.sv
// Top level of the sorted contraction queue: cell chain, sequencer and result register.
//
//  channel  | ports                        | direction | beat
//  ---------+------------------------------+-----------+-------------------------------
//  request  | req_valid/req_stall, req_*   | in        | one op: push/delete/find/read
//  response | rsp_valid/rsp_stall, rsp_*   | out       | one result per request beat
//
// Each op walks the cell chain before the next request beat is taken: a probe travels
// the chain one cell per cycle, and the result register loads once the walk is done
// and the register is free. List edits (insert with shift, delete with close-up) happen at
// the end of the walk, every cell moving to or from its neighbor at once.
// Synchronous active-high reset clears the fill count and control; entries stay undefined.
// A stalled response holds the finished op at the end of its walk; the list is not touched
// until the result register is free.
module sorted_contraction_queue_unit #(
   parameter int QUEUE_DEPTH = 256,
   parameter int VERTEX_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_cost_key,
   input  logic [15:0] req_vertex_a,
   input  logic [15:0] req_vertex_b,
   input  logic [31:0] req_pos_x,
   input  logic [31:0] req_pos_y,
   input  logic [31:0] req_pos_z,
   input  logic [7:0]  req_slot,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_found,
   output logic [7:0]  rsp_where_at,
   output logic [8:0]  rsp_fill,
   output logic [31:0] rsp_out_cost,
   output logic [15:0] rsp_out_vertex_a,
   output logic [15:0] rsp_out_vertex_b,
   output logic [31:0] rsp_out_pos_x,
   output logic [31:0] rsp_out_pos_y,
   output logic [31:0] rsp_out_pos_z
);
   import scq_pkg::*;

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = 4 * 32 + 2 * VERTEX_BITS;
   localparam int PW = 1 + IW + EW;
   localparam logic [CW-1:0] DEPTH_CNT = CW'(QUEUE_DEPTH);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WALK = 1'b1;

   typedef struct packed {
      logic [31:0]            cost;
      logic [VERTEX_BITS-1:0] va;
      logic [VERTEX_BITS-1:0] vb;
      logic [31:0]            pos_x;
      logic [31:0]            pos_y;
      logic [31:0]            pos_z;
   } entry_type;

   typedef struct packed {
      logic          hit;
      logic [IW-1:0] idx;
      entry_type     entry;
   } probe_type;

   // control
   logic          state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] total_ff, total_in;
   logic          accept, finish, full;

   // latched request
   logic [1:0]    op_ff;
   entry_type     key_ff;
   logic [7:0]    slot_ff;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    status_ff, status_in;
   logic          found_ff, found_in;
   logic [7:0]    where_ff, where_in;
   logic [8:0]    fill_ff, fill_in;
   entry_type     rent_ff, rent_in;

   // chain
   scq_cmd_type   cmd;
   logic [EW-1:0] entry_bus [QUEUE_DEPTH];
   logic [PW-1:0] probe_bus [QUEUE_DEPTH];
   probe_type     probe_last;

   assign accept     = req_valid && !req_stall;
   assign req_stall  = (state_ff != S_IDLE);
   assign probe_last = probe_type'(probe_bus[QUEUE_DEPTH-1]);
   assign full       = (total_ff == DEPTH_CNT);
   // walk done and result register free
   assign finish     = (state_ff == S_WALK) && (cnt_ff == DEPTH_CNT) &&
                       (!rsp_valid_ff || !rsp_stall);

   assign cmd.op          = op_ff;
   assign cmd.commit_push = finish && (op_ff == OP_PUSH) && !full;
   assign cmd.commit_del  = finish && (op_ff == OP_DELETE) && probe_last.hit;

   // sequencer
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_WALK;
               cnt_in   = '0;
            end
         end
         S_WALK: begin
            if (cnt_ff != DEPTH_CNT) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (finish) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      total_in = total_ff;
      if (cmd.commit_push) begin
         total_in = total_ff + CW'(1);
      end else if (cmd.commit_del) begin
         total_in = total_ff - CW'(1);
      end
   end

   // result formation from the probe leaving the last cell
   always_comb begin
      status_in = ST_OK;
      found_in  = 1'b0;
      where_in  = '0;
      rent_in   = '0;
      fill_in   = 9'(total_in);
      case (op_ff)
         OP_PUSH: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               where_in = 8'(probe_last.idx);
            end
         end
         OP_DELETE: begin
            if (!probe_last.hit) begin
               status_in = ST_BAD;
            end
         end
         OP_FIND: begin
            if (probe_last.hit) begin
               found_in = 1'b1;
               where_in = 8'(probe_last.idx);
               rent_in  = probe_last.entry;
            end else begin
               status_in = ST_BAD;
            end
         end
         default: begin
            if (probe_last.hit) begin
               rent_in = probe_last.entry;
            end else begin
               status_in = ST_BAD;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // request fields, vertices cut to VERTEX_BITS
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff        <= req_op;
         key_ff.cost  <= req_cost_key;
         key_ff.va    <= VERTEX_BITS'(req_vertex_a);
         key_ff.vb    <= VERTEX_BITS'(req_vertex_b);
         key_ff.pos_x <= req_pos_x;
         key_ff.pos_y <= req_pos_y;
         key_ff.pos_z <= req_pos_z;
         slot_ff      <= req_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         status_ff <= status_in;
         found_ff  <= found_in;
         where_ff  <= where_in;
         fill_ff   <= fill_in;
         rent_ff   <= rent_in;
      end
   end

   // cell chain: entries move to neighbors on edits, probe moves one cell per cycle
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      logic [EW-1:0] prev_w, next_w;
      logic [PW-1:0] probe_w;

      if (g == 0) begin : g_head
         assign prev_w  = key_ff;
         assign probe_w = '0;
      end else begin : g_body
         assign prev_w  = entry_bus[g-1];
         assign probe_w = probe_bus[g-1];
      end

      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign next_w = entry_bus[g];
      end else begin : g_inner
         assign next_w = entry_bus[g+1];
      end

      scq_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .VERTEX_BITS (VERTEX_BITS),
         .INDEX       (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .key_entry  (key_ff),
         .slot       (slot_ff),
         .at_idx     (probe_last.idx),
         .total      (total_ff),
         .prev_entry (prev_w),
         .next_entry (next_w),
         .probe_prev (probe_w),
         .entry_out  (entry_bus[g]),
         .probe_out  (probe_bus[g])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found        = found_ff;
   assign rsp_where_at     = where_ff;
   assign rsp_fill         = fill_ff;
   assign rsp_out_cost     = rent_ff.cost;
   assign rsp_out_vertex_a = 16'(rent_ff.va);
   assign rsp_out_vertex_b = 16'(rent_ff.vb);
   assign rsp_out_pos_x    = rent_ff.pos_x;
   assign rsp_out_pos_y    = rent_ff.pos_y;
   assign rsp_out_pos_z    = rent_ff.pos_z;

`ifndef NO_ASSERTIONS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= DEPTH_CNT)
      else $error("fill count beyond depth");

   a_push_slot: assert property (@(posedge clock) disable iff (reset)
      (finish && op_ff == OP_PUSH && !full) |-> probe_last.hit)
      else $error("push found no insertion slot");

   a_fill_out: assert property (@(posedge clock) disable iff (reset)
      finish |=> (rsp_valid_ff && rsp_fill == 9'(total_ff)))
      else $error("reported fill differs from held count");
`endif

endmodule

// File: tb/sorted_contraction_queue_unit_test.sv
// Self-checking testbench for the sorted contraction queue: directed table, then random beats.
module sorted_contraction_queue_unit_test;
   import scq_pkg::*;

   localparam int QUEUE_DEPTH = 256;
   localparam int VERTEX_BITS = 16;
   // one op walks the whole chain, then the result register loads
   localparam int OP_CYCLES   = QUEUE_DEPTH + 2;
   localparam int LONG_HOLD   = 6 * OP_CYCLES;
   localparam int HOLD_AFTER  = 40;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int PRINT_CAP   = 100;
   localparam logic [15:0] VERTEX_MASK = 16'(32'hFFFF_FFFF >> (32 - VERTEX_BITS));

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] cost;
      logic [15:0] va, vb;
      logic [31:0] px, py, pz;
      logic [7:0]  slot;
   } contraction_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        found;
      logic [7:0]  where_at;
      logic [8:0]  fill;
      logic [31:0] cost;
      logic [15:0] va, vb;
      logic [31:0] px, py, pz;
   } contraction_rsp_type;

   typedef struct packed {
      logic [31:0] cost;
      logic [15:0] va, vb;
      logic [31:0] px, py, pz;
   } contraction_entry_type;

   // directed row; where typed is set the short result below is the expectation
   // (entry fields and found are zero in every such row)
   typedef struct packed {
      contraction_req_type req;
      logic                typed;
      logic [1:0]          status;
      logic [7:0]          where_at;
      logic [8:0]          fill;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op = OP_READ;
   logic [31:0] req_cost_key = '0;
   logic [15:0] req_vertex_a = '0;
   logic [15:0] req_vertex_b = '0;
   logic [31:0] req_pos_x = '0;
   logic [31:0] req_pos_y = '0;
   logic [31:0] req_pos_z = '0;
   logic [7:0]  req_slot = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic        rsp_found;
   logic [7:0]  rsp_where_at;
   logic [8:0]  rsp_fill;
   logic [31:0] rsp_out_cost;
   logic [15:0] rsp_out_vertex_a;
   logic [15:0] rsp_out_vertex_b;
   logic [31:0] rsp_out_pos_x;
   logic [31:0] rsp_out_pos_y;
   logic [31:0] rsp_out_pos_z;

   // shadow of the list, kept in descending cost order, and results still owed
   contraction_entry_type sorted_entries[$];
   contraction_rsp_type   awaited_results[$];
   stim_row_type          stim_rows[22];

   int error_count    = 0;
   int beats_accepted = 0;
   int cycle_count    = 0;

   sorted_contraction_queue_unit #(
      .QUEUE_DEPTH(QUEUE_DEPTH),
      .VERTEX_BITS(VERTEX_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_cost_key    (req_cost_key),
      .req_vertex_a    (req_vertex_a),
      .req_vertex_b    (req_vertex_b),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_slot        (req_slot),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_found       (rsp_found),
      .rsp_where_at    (rsp_where_at),
      .rsp_fill        (rsp_fill),
      .rsp_out_cost    (rsp_out_cost),
      .rsp_out_vertex_a(rsp_out_vertex_a),
      .rsp_out_vertex_b(rsp_out_vertex_b),
      .rsp_out_pos_x   (rsp_out_pos_x),
      .rsp_out_pos_y   (rsp_out_pos_y),
      .rsp_out_pos_z   (rsp_out_pos_z)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- prediction

   function automatic contraction_rsp_type entry_fields(input contraction_entry_type e);
      contraction_rsp_type res;
      res = '0;
      res.cost = e.cost;
      res.va   = e.va;
      res.vb   = e.vb;
      res.px   = e.px;
      res.py   = e.py;
      res.pz   = e.pz;
      return res;
   endfunction

   // applies one op to the shadow list and returns the result it should give
   task automatic apply_queue_op(input contraction_req_type r, output contraction_rsp_type res);
      contraction_entry_type e;
      logic [15:0] va, vb;
      int at;
      res = '0;
      va  = r.va & VERTEX_MASK;
      vb  = r.vb & VERTEX_MASK;
      at  = 0;
      case (r.op)
         OP_PUSH: begin
            if (sorted_entries.size() >= QUEUE_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // stable: lands behind every entry of equal or greater cost
               while (at < sorted_entries.size() && sorted_entries[at].cost >= r.cost)
                  at++;
               e = '{r.cost, va, vb, r.px, r.py, r.pz};
               sorted_entries.insert(at, e);
               res.where_at = 8'(at);
            end
         end
         OP_DELETE: begin
            if (r.slot >= sorted_entries.size())
               res.status = ST_BAD;
            else
               sorted_entries.delete(int'(r.slot));
         end
         OP_FIND: begin
            res.status = ST_BAD;
            for (at = 0; at < sorted_entries.size(); at++) begin
               e = sorted_entries[at];
               if ((e.va == va && e.vb == vb) || (e.va == vb && e.vb == va)) begin
                  res          = entry_fields(e);
                  res.found    = 1'b1;
                  res.where_at = 8'(at);
                  break;
               end
            end
         end
         default: begin
            if (r.slot >= sorted_entries.size())
               res.status = ST_BAD;
            else
               res = entry_fields(sorted_entries[r.slot]);
         end
      endcase
      res.fill = 9'(sorted_entries.size());
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   // mostly back-to-back, often a short gap, now and then a long gap
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 6);
      return $urandom_range(20, 300);
   endfunction

   // random op; read takes whatever share push, delete and find leave over.
   // Fields an op ignores still carry random bits.
   function automatic contraction_req_type random_request(input int push_pct, input int del_pct,
                                                          input int find_pct);
      contraction_req_type r;
      contraction_entry_type e;
      int roll, n;
      n      = sorted_entries.size();
      r.cost = $urandom;
      r.va   = 16'($urandom);
      r.vb   = 16'($urandom);
      r.px   = $urandom;
      r.py   = $urandom;
      r.pz   = $urandom;
      r.slot = 8'($urandom);
      roll   = $urandom_range(0, 99);
      if (roll < push_pct)
         r.op = OP_PUSH;
      else if (roll < push_pct + del_pct)
         r.op = OP_DELETE;
      else if (roll < push_pct + del_pct + find_pct)
         r.op = OP_FIND;
      else
         r.op = OP_READ;
      roll = $urandom_range(0, 9);
      case (r.op)
         OP_PUSH: begin
            // ties with live costs exercise the stable insert
            if (roll < 2) begin
               r.cost = $urandom_range(0, 15);
            end else if (roll < 4 && n > 0) begin
               r.cost = sorted_entries[$urandom_range(0, n - 1)].cost;
            end else if (roll == 4) begin
               case ($urandom_range(0, 3))
                  0: r.cost = 32'h0000_0000;
                  1: r.cost = 32'hFFFF_FFFF;
                  2: r.cost = 32'h7F80_0000;
                  default: r.cost = 32'h3F80_0000;
               endcase
            end
            // narrow vertex range so duplicate edges show up
            if ($urandom_range(0, 3) == 0) begin
               r.va = 16'($urandom_range(0, 7));
               r.vb = 16'($urandom_range(0, 7));
            end
         end
         OP_FIND: begin
            if (roll < 6 && n > 0) begin
               e = sorted_entries[$urandom_range(0, n - 1)];
               if ($urandom_range(0, 1)) begin
                  r.va = e.va;
                  r.vb = e.vb;
               end else begin
                  r.va = e.vb;
                  r.vb = e.va;
               end
            end else if (roll < 8) begin
               r.va = 16'($urandom_range(0, 7));
               r.vb = 16'($urandom_range(0, 7));
            end
         end
         default: begin
            if (roll < 7 && n > 0)
               r.slot = 8'($urandom_range(0, n - 1));
            else if (roll < 8)
               r.slot = 8'(n);
         end
      endcase
      return r;
   endfunction

   // offers one beat, holds it through stalls, predicts on acceptance
   task automatic send_beat(input contraction_req_type r, input logic typed,
                            input contraction_rsp_type typed_rsp);
      contraction_rsp_type want;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_op       <= r.op;
      req_cost_key <= r.cost;
      req_vertex_a <= r.va;
      req_vertex_b <= r.vb;
      req_pos_x    <= r.px;
      req_pos_y    <= r.py;
      req_pos_z    <= r.pz;
      req_slot     <= r.slot;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      apply_queue_op(r, want);
      if (typed)
         want = typed_rsp;
      awaited_results.push_back(want);
      beats_accepted++;
   endtask

   // lowers valid right at an acceptance edge, then waits for every result owed
   task automatic sender_pause();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_results.size() != 0);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      if (error_count < PRINT_CAP)
         $display("MISMATCH cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   always @(posedge clock) begin
      contraction_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
         end else begin
            want = awaited_results.pop_front();
            compare_field("status",   rsp_status,       want.status);
            compare_field("found",    rsp_found,        want.found);
            compare_field("where_at", rsp_where_at,     want.where_at);
            compare_field("fill",     rsp_fill,         want.fill);
            compare_field("cost",     rsp_out_cost,     want.cost);
            compare_field("vertex_a", rsp_out_vertex_a, want.va);
            compare_field("vertex_b", rsp_out_vertex_b, want.vb);
            compare_field("pos_x",    rsp_out_pos_x,    want.px);
            compare_field("pos_y",    rsp_out_pos_y,    want.py);
            compare_field("pos_z",    rsp_out_pos_z,    want.pz);
         end
      end
   end

   // ---------------------------------------------------------------- result side

   // random stall bursts between open stretches, some of them long; once, after
   // HOLD_AFTER beats, one long hold-off so the chain backs up into req_stall
   initial begin : result_side
      int stall_len, open_len;
      bit held_off;
      held_off = 1'b0;
      forever begin
         if (!held_off && beats_accepted >= HOLD_AFTER) begin
            held_off  = 1'b1;
            stall_len = LONG_HOLD;
         end else begin
            stall_len = ($urandom_range(0, 9) < 4) ? 0 : pick_gap();
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         open_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 20)
                                                : $urandom_range(50, 1500);
         // cut an open stretch short when the long hold-off is due
         do begin
            @(posedge clock);
            open_len--;
         end while (open_len > 0 && (held_off || beats_accepted < HOLD_AFTER));
      end
   end

   // ---------------------------------------------------------------- watchdog

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------- stimulus

   initial begin : stimulus
      contraction_rsp_type typed_rsp;

      // '{'{op, cost, va, vb, px, py, pz, slot}, typed, status, where_at, fill}
      stim_rows = '{
         // empty list: lookups and delete all miss
         '{'{OP_READ,   0, 0, 0, 0, 0, 0, 8'd0},       1'b1, ST_BAD, 0, 0},
         '{'{OP_DELETE, 0, 0, 0, 0, 0, 0, 8'd0},       1'b1, ST_BAD, 0, 0},
         '{'{OP_FIND,   0, 16'd1, 16'd2, 0, 0, 0, 0},  1'b1, ST_BAD, 0, 0},
         // extreme costs, vertices and payload patterns
         '{'{OP_PUSH, 32'hFFFF_FFFF, 16'hFFFF, 16'h0000,
             32'hFFFF_FFFF, 32'h0000_0000, 32'hAAAA_AAAA, 8'hFF}, 1'b1, ST_OK, 0, 1},
         '{'{OP_PUSH, 32'h0000_0000, 16'h0000, 16'hFFFF,
             32'h0000_0000, 32'hFFFF_FFFF, 32'h5555_5555, 8'h00}, 1'b1, ST_OK, 1, 2},
         // equal costs go behind the ones already there
         '{'{OP_PUSH, 32'h0000_0000, 16'd1, 16'd2, 1, 2, 3, 0},   1'b1, ST_OK, 2, 3},
         '{'{OP_PUSH, 32'h3F80_0000, 16'd3, 16'd4, 4, 5, 6, 0},   1'b1, ST_OK, 1, 4},
         '{'{OP_PUSH, 32'h3F80_0000, 16'd5, 16'd6, 7, 8, 9, 0},   1'b1, ST_OK, 2, 5},
         // reads: first, last, one past the end, top of the slot range
         '{'{OP_READ, 0, 0, 0, 0, 0, 0, 8'd0},         1'b0, 0, 0, 0},
         '{'{OP_READ, 0, 0, 0, 0, 0, 0, 8'd4},         1'b0, 0, 0, 0},
         '{'{OP_READ, 0, 0, 0, 0, 0, 0, 8'd5},         1'b1, ST_BAD, 0, 5},
         '{'{OP_READ, 0, 0, 0, 0, 0, 0, 8'd255},       1'b1, ST_BAD, 0, 5},
         // find in reversed orientation, first of two orientations, and a miss
         '{'{OP_FIND, 0, 16'd2, 16'd1, 0, 0, 0, 0},    1'b0, 0, 0, 0},
         '{'{OP_FIND, 0, 16'h0000, 16'hFFFF, 0, 0, 0, 0}, 1'b0, 0, 0, 0},
         '{'{OP_FIND, 0, 16'd7, 16'd7, 0, 0, 0, 0},    1'b1, ST_BAD, 0, 5},
         // duplicate edge ahead of the old one: find returns the first
         '{'{OP_PUSH, 32'h4000_0000, 16'd1, 16'd2, 10, 11, 12, 0}, 1'b1, ST_OK, 1, 6},
         '{'{OP_FIND, 0, 16'd1, 16'd2, 0, 0, 0, 0},    1'b0, 0, 0, 0},
         // delete head, delete tail, out-of-range deletes
         '{'{OP_DELETE, 0, 0, 0, 0, 0, 0, 8'd0},       1'b1, ST_OK, 0, 5},
         '{'{OP_DELETE, 0, 0, 0, 0, 0, 0, 8'd4},       1'b1, ST_OK, 0, 4},
         '{'{OP_DELETE, 0, 0, 0, 0, 0, 0, 8'd200},     1'b1, ST_BAD, 0, 4},
         '{'{OP_DELETE, 0, 0, 0, 0, 0, 0, 8'd255},     1'b1, ST_BAD, 0, 4},
         '{'{OP_READ,   0, 0, 0, 0, 0, 0, 8'd0},       1'b0, 0, 0, 0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_rows[n]) begin
         typed_rsp          = '0;
         typed_rsp.status   = stim_rows[n].status;
         typed_rsp.where_at = stim_rows[n].where_at;
         typed_rsp.fill     = stim_rows[n].fill;
         send_beat(stim_rows[n].req, stim_rows[n].typed, typed_rsp);
      end

      // mixed traffic over a short list; the long result hold-off lands in here
      repeat (60) send_beat(random_request(45, 15, 20), 1'b0, '0);

      // sender goes quiet until the block has answered everything
      sender_pause();

      // climb to a full list, mostly pushes
      while (sorted_entries.size() < QUEUE_DEPTH)
         send_beat(random_request(90, 2, 4), 1'b0, '0);

      // at capacity: pushes are dropped, a delete opens a single hole
      repeat (30) send_beat(random_request(45, 10, 25), 1'b0, '0);

      // delete-heavy tail
      repeat (40) send_beat(random_request(20, 60, 10), 1'b0, '0);

      sender_pause();
      // room for a stray extra result to show up
      repeat (2 * OP_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sorted_contraction_queue_unit.f
src/scq_pkg.sv
src/scq_cell.sv
src/sorted_contraction_queue_unit.sv
tb/sorted_contraction_queue_unit_test.sv
